@@ rtl/tcsl_pkg.sv @@
// Package for the transitive closure / component leader block.
// Holds the channel word types and the microcode field encodings; no dependencies.
`default_nettype none

package tcsl_pkg;

    // Input word: one edge insert or one leader query
    typedef struct packed {
        logic       action;
        logic [5:0] from_node;
        logic [5:0] to_node;
        logic [5:0] query_node;
    } t_in_item;

    // Output word: leader of the queried node
    typedef struct packed {
        logic [5:0] leader_node;
        logic       found;
    } t_out_item;

    // Input action codes
    localparam logic ACT_INSERT = 1'b0;
    localparam logic ACT_QUERY  = 1'b1;

    // Configuration register map (word index taken from paddr[2])
    localparam logic REG_NODE_COUNT = 1'b0;
    localparam logic [6:0] NODE_COUNT_RESET = 7'd64;

    // Sequencer steps
    typedef enum logic [3:0] {
        ST_INIT,
        ST_WAIT,
        ST_DISP,
        ST_INS_WR,
        ST_PIV,
        ST_PLAT,
        ST_ROW,
        ST_LDQ,
        ST_QLAT,
        ST_SCAN,
        ST_MISS
    } t_step;

    // Read address source
    typedef enum logic [1:0] {
        R_SRC,
        R_PIVOT,
        R_ROW,
        R_QUERY
    } t_rd;

    // Write operation
    typedef enum logic [1:0] {
        W_NONE,
        W_INIT,
        W_INS,
        W_ROW
    } t_wr;

    // Pivot counter operation
    typedef enum logic [1:0] {
        P_KEEP,
        P_CLR,
        P_INC_IF
    } t_pop;

    // Row counter operation
    typedef enum logic [1:0] {
        I_KEEP,
        I_CLR,
        I_INC,
        I_INC_NOHIT
    } t_iop;

    // Result load, applied when the step condition holds
    typedef enum logic [1:0] {
        O_NONE,
        O_HIT,
        O_MISS
    } t_out;

    // Jump conditions
    typedef enum logic [2:0] {
        C_ALWAYS,
        C_INIT_DONE,
        C_ACCEPT,
        C_QUERY,
        C_PIV_DONE,
        C_ROW_DONE,
        C_QINR,
        C_HIT_FREE
    } t_cond;

    localparam t_cond C_OUT_FREE = C_HIT_FREE;

    // One microcode word
    typedef struct packed {
        logic  in_ready;
        t_rd   rd;
        t_wr   wr;
        logic  latch;
        t_pop  p_op;
        t_iop  i_op;
        t_out  out;
        t_cond cond;
        t_step jt;
        t_step jf;
    } t_ctrl;

endpackage

`default_nettype wire

@@ rtl/tcsl_stream_if.sv @@
// Valid/ready channel carrying one word of a type given by parameter.
// Depends on nothing; word types come from tcsl_pkg at instantiation.
`default_nettype none

interface tcsl_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

`default_nettype wire

@@ rtl/transitive_closure_scc_leader.sv @@
// Transitive closure / strongly connected component leader, microcoded sequencer.
// Insert: after accept, reads the source row, then writes it back with the edge set (read row, write row).
// Query: closes the matrix one pivot at a time over the n active nodes, then finds leader L <= q
//   (a miss when q is out of range); the closure streams one row a cycle.
// One item at a time; a result waits in an output register and holds the final step.
// Reset (synchronous): then writes the identity matrix row by row, input held off.
`default_nettype none

module transitive_closure_scc_leader
    import tcsl_pkg::*;
#(
    parameter int MAX_NODES = 64
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    tcsl_stream_if.sink      i_in,
    tcsl_stream_if.source    o_out,
    input  wire logic        psel,
    input  wire logic        penable,
    input  wire logic        pwrite,
    input  wire logic [2:0]  paddr,
    input  wire logic [31:0] pwdata,
    output logic      [31:0] prdata,
    output logic             pready
);

    localparam int IW = $clog2(MAX_NODES);
    localparam int CW = $clog2(MAX_NODES + 1);
    localparam int NW = (CW > 7) ? CW : 7;
    localparam logic [MAX_NODES-1:0] ONE_BIT = MAX_NODES'(1);

    t_step                r_step, n_step;
    t_ctrl                ctrl;
    logic                 cond_met;
    logic [CW-1:0]        r_p, n_p;
    logic [CW-1:0]        r_i, n_i;
    logic [CW-1:0]        i_prev;
    logic [CW-1:0]        row_rd;
    logic [6:0]           r_node_count;
    t_in_item             r_item;
    logic [MAX_NODES-1:0] r_pivot;
    t_out_item            r_out;
    logic                 r_out_valid;

    logic [NW-1:0]        n_act;
    logic [MAX_NODES-1:0] col_mask;
    logic [IW-1:0]        src_idx, dst_idx, q_idx;
    logic                 ins_ok, q_in_range, scan_hit, out_free, accept;

    logic                 ram_we;
    logic [IW-1:0]        ram_waddr, ram_raddr;
    logic [MAX_NODES-1:0] ram_wdata, ram_rdata;

    // Microcode table
    always_comb begin
        ctrl = '{in_ready: 1'b0, rd: R_ROW, wr: W_NONE, latch: 1'b0, p_op: P_KEEP,
                 i_op: I_KEEP, out: O_NONE, cond: C_ALWAYS, jt: ST_WAIT, jf: ST_WAIT};
        case (r_step)
            ST_INIT: begin
                ctrl.wr   = W_INIT;
                ctrl.i_op = I_INC;
                ctrl.cond = C_INIT_DONE;
                ctrl.jt   = ST_WAIT;
                ctrl.jf   = ST_INIT;
            end
            ST_WAIT: begin
                ctrl.in_ready = 1'b1;
                ctrl.p_op     = P_CLR;
                ctrl.cond     = C_ACCEPT;
                ctrl.jt       = ST_DISP;
                ctrl.jf       = ST_WAIT;
            end
            ST_DISP: begin
                ctrl.rd   = R_SRC;
                ctrl.cond = C_QUERY;
                ctrl.jt   = ST_PIV;
                ctrl.jf   = ST_INS_WR;
            end
            ST_INS_WR: begin
                ctrl.wr = W_INS;
                ctrl.jt = ST_WAIT;
            end
            ST_PIV: begin
                ctrl.rd   = R_PIVOT;
                ctrl.i_op = I_CLR;
                ctrl.cond = C_PIV_DONE;
                ctrl.jt   = ST_LDQ;
                ctrl.jf   = ST_PLAT;
            end
            ST_PLAT: begin
                ctrl.rd    = R_ROW;
                ctrl.latch = 1'b1;
                ctrl.i_op  = I_INC;
                ctrl.jt    = ST_ROW;
            end
            ST_ROW: begin
                ctrl.rd   = R_ROW;
                ctrl.wr   = W_ROW;
                ctrl.i_op = I_INC;
                ctrl.p_op = P_INC_IF;
                ctrl.cond = C_ROW_DONE;
                ctrl.jt   = ST_PIV;
                ctrl.jf   = ST_ROW;
            end
            ST_LDQ: begin
                ctrl.rd   = R_QUERY;
                ctrl.cond = C_QINR;
                ctrl.jt   = ST_QLAT;
                ctrl.jf   = ST_MISS;
            end
            ST_QLAT: begin
                ctrl.rd    = R_ROW;
                ctrl.latch = 1'b1;
                ctrl.i_op  = I_INC;
                ctrl.jt    = ST_SCAN;
            end
            ST_SCAN: begin
                ctrl.rd   = R_ROW;
                ctrl.i_op = I_INC_NOHIT;
                ctrl.out  = O_HIT;
                ctrl.cond = C_HIT_FREE;
                ctrl.jt   = ST_WAIT;
                ctrl.jf   = ST_SCAN;
            end
            ST_MISS: begin
                ctrl.out  = O_MISS;
                ctrl.cond = C_OUT_FREE;
                ctrl.jt   = ST_WAIT;
                ctrl.jf   = ST_MISS;
            end
            default: begin
                ctrl.jt = ST_INIT;
                ctrl.jf = ST_INIT;
            end
        endcase
    end

    // Active node count, clamped to the matrix size
    always_comb begin
        if (NW'(r_node_count) > NW'(MAX_NODES)) begin
            n_act = NW'(MAX_NODES);
        end else begin
            n_act = NW'(r_node_count);
        end
    end

    // Column mask of active nodes
    always_comb begin
        for (int j = 0; j < MAX_NODES; j++) begin
            col_mask[j] = (NW'(j) < n_act);
        end
    end

    // Datapath decode
    assign i_prev     = r_i - CW'(1);
    assign row_rd     = n_i - CW'(1);
    assign src_idx    = IW'(r_item.from_node);
    assign dst_idx    = IW'(r_item.to_node);
    assign q_idx      = IW'(r_item.query_node);
    assign ins_ok     = (NW'(r_item.from_node) < n_act) && (NW'(r_item.to_node) < n_act);
    assign q_in_range = NW'(r_item.query_node) < n_act;
    assign scan_hit   = ram_rdata[q_idx] && r_pivot[i_prev[IW-1:0]];
    assign out_free   = !r_out_valid || o_out.ready;
    assign accept     = i_in.valid && ctrl.in_ready;

    // Evaluate the jump condition
    always_comb begin
        case (ctrl.cond)
            C_ALWAYS:    cond_met = 1'b1;
            C_INIT_DONE: cond_met = (r_i == CW'(MAX_NODES - 1));
            C_ACCEPT:    cond_met = accept;
            C_QUERY:     cond_met = (r_item.action == ACT_QUERY);
            C_PIV_DONE:  cond_met = (NW'(r_p) == n_act);
            C_ROW_DONE:  cond_met = (NW'(r_i) == n_act);
            C_QINR:      cond_met = q_in_range;
            C_HIT_FREE:  cond_met = out_free && ((ctrl.out == O_MISS) || scan_hit);
            default:     cond_met = 1'b0;
        endcase
    end

    // Next step and counters
    always_comb begin
        n_step = cond_met ? ctrl.jt : ctrl.jf;
        case (ctrl.p_op)
            P_CLR:    n_p = '0;
            P_INC_IF: n_p = cond_met ? r_p + CW'(1) : r_p;
            default:  n_p = r_p;
        endcase
        case (ctrl.i_op)
            I_CLR:       n_i = '0;
            I_INC:       n_i = r_i + CW'(1);
            I_INC_NOHIT: n_i = scan_hit ? r_i : r_i + CW'(1);
            default:     n_i = r_i;
        endcase
    end

    // Row RAM read address; row steps fetch the row inspected in the next cycle
    always_comb begin
        case (ctrl.rd)
            R_SRC:   ram_raddr = src_idx;
            R_PIVOT: ram_raddr = r_p[IW-1:0];
            R_QUERY: ram_raddr = q_idx;
            default: ram_raddr = row_rd[IW-1:0];
        endcase
    end

    // Row RAM write: identity fill, edge set, closure row update
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_i[IW-1:0];
        ram_wdata = ONE_BIT << r_i[IW-1:0];
        case (ctrl.wr)
            W_INIT: begin
                ram_we = 1'b1;
            end
            W_INS: begin
                ram_we    = ins_ok;
                ram_waddr = src_idx;
                ram_wdata = ram_rdata | (ONE_BIT << dst_idx);
            end
            W_ROW: begin
                ram_we    = ram_rdata[r_p[IW-1:0]];
                ram_waddr = i_prev[IW-1:0];
                ram_wdata = ram_rdata | (r_pivot & col_mask);
            end
            default: begin
                ram_we = 1'b0;
            end
        endcase
    end

    tcsl_ram #(
        .WIDTH (MAX_NODES),
        .DEPTH (MAX_NODES)
    ) u_rows (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // Control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_step       <= ST_INIT;
            r_p          <= '0;
            r_i          <= '0;
            r_out_valid  <= 1'b0;
            r_node_count <= NODE_COUNT_RESET;
        end else begin
            r_step <= n_step;
            r_p    <= n_p;
            r_i    <= n_i;
            if (cond_met && (ctrl.out != O_NONE)) begin
                r_out_valid <= 1'b1;
            end else if (o_out.ready) begin
                r_out_valid <= 1'b0;
            end
            if (psel && penable && pwrite && (paddr[2] == REG_NODE_COUNT)) begin
                r_node_count <= pwdata[6:0];
            end
        end
    end

    // Payload registers: input word, pivot row, result word
    always_ff @(posedge i_clk) begin
        if (accept) begin
            r_item <= i_in.data;
        end
        if (ctrl.latch) begin
            r_pivot <= ram_rdata;
        end
        if (cond_met && (ctrl.out == O_HIT)) begin
            r_out.leader_node <= 6'(i_prev);
            r_out.found       <= 1'b1;
        end else if (cond_met && (ctrl.out == O_MISS)) begin
            r_out.leader_node <= '0;
            r_out.found       <= 1'b0;
        end
    end

    // Ports
    assign i_in.ready = ctrl.in_ready;
    assign o_out.valid = r_out_valid;
    assign o_out.data  = r_out;
    assign pready      = 1'b1;
    assign prdata      = (paddr[2] == REG_NODE_COUNT) ? {25'd0, r_node_count} : 32'd0;

endmodule

`default_nettype wire

@@ rtl/tcsl_ram.sv @@
// Generic single write port, single read port RAM with registered read.
// No dependencies.
`default_nettype none

module tcsl_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 64
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    // Write and registered read
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end

endmodule

`default_nettype wire
